// File: design/hpk_pkg.sv
// ----------------------------------------------------------------------------
// hpk_pkg
// Shared types and codes for the header block tokenizer: item formats,
// token and error codes, parser phases and queue sizing.
// ----------------------------------------------------------------------------
package hpk_pkg;

  // Default depth of the result queue.
  localparam int HPK_QUEUE_DEPTH = 4;

  // Reset value of the table size limit register.
  localparam logic [31:0] HPK_LIMIT_RESET = 32'd4096;

  // Token kinds.
  localparam logic [2:0] TK_INDEXED  = 3'd0;
  localparam logic [2:0] TK_LITERAL  = 3'd1;
  localparam logic [2:0] TK_SIZE_UPD = 3'd2;
  localparam logic [2:0] TK_STR_HDR  = 3'd3;
  localparam logic [2:0] TK_STR_BYTE = 3'd4;
  localparam logic [2:0] TK_BLK_END  = 3'd5;
  localparam logic [2:0] TK_ERROR    = 3'd6;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
  localparam logic [2:0] ERR_LATE_SIZE = 3'd2;
  localparam logic [2:0] ERR_OVER_LIM  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  // Shift reached by a continuation byte that may not be followed by another.
  localparam logic [6:0] SHIFT_LIMIT = 7'd63;
  localparam logic [5:0] SHIFT_STEP  = 6'd7;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_FIRST     = 3'd0,
    PH_PFX_CONT  = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_CONT  = 3'd3,
    PH_STRING    = 3'd4
  } phase_t;

  // Representation kinds; the literal kinds minus one give the field mode.
  typedef enum logic [2:0] {
    REP_INDEXED = 3'd0,
    REP_INCR    = 3'd1,
    REP_WITHOUT = 3'd2,
    REP_NEVER   = 3'd3,
    REP_SIZE    = 3'd4
  } rep_t;

  // One input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } in_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  token_kind;
    logic [63:0] value;
    logic [1:0]  field_mode;
    logic        is_huffman;
    logic        string_is_value;
    logic [7:0]  string_byte;
    logic [2:0]  error_code;
    logic        field_done;
    logic        last;
  } out_t;

  // Results produced by one input word, in order.
  typedef struct packed {
    logic [1:0] count;
    out_t       r0;
    out_t       r1;
  } push_t;

endpackage

// File: design/hpk_parser.sv
// ----------------------------------------------------------------------------
// hpk_parser
// Representation parser: holds the decode state and the size limit register,
// and turns one input word into up to two result words.
// ----------------------------------------------------------------------------
module hpk_parser
  import hpk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  in_t         item,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output push_t       push
);

  phase_t      phase_r, phase_nxt;
  rep_t        rk_r, rk_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [5:0]  shift_r, shift_nxt;
  logic [63:0] left_r, left_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic        huff_r, huff_nxt;
  logic        nofield_r, nofield_nxt;
  logic        err_r, err_nxt;
  logic [31:0] limit_r;

  // Decode of one word against the current state.
  always_comb begin
    logic [7:0]  b;
    logic [7:0]  pmask;
    logic [7:0]  pv;
    logic        do_start;
    logic        do_cont;
    logic        do_complete;
    logic        do_finish;
    logic        do_fail;
    logic        in_str;
    logic [63:0] cval;
    logic [63:0] sum;
    logic [63:0] dec;
    logic [6:0]  shift_sum;
    logic [1:0]  pend_dec;
    logic        isval;
    logic [2:0]  fail_code;
    logic        tok_vld;
    out_t        tok;
    out_t        close;

    b           = item.data_byte;
    pmask       = 8'h00;
    pv          = 8'h00;
    do_start    = 1'b0;
    do_cont     = 1'b0;
    do_complete = 1'b0;
    do_finish   = 1'b0;
    do_fail     = 1'b0;
    in_str      = 1'b0;
    cval        = 64'd0;
    sum         = 64'd0;
    dec         = 64'd0;
    shift_sum   = 7'd0;
    pend_dec    = 2'd0;
    isval       = (pending_r == 2'd1);
    fail_code   = ERR_NONE;
    tok_vld     = 1'b0;
    tok         = '0;
    close       = '0;

    phase_nxt   = phase_r;
    rk_nxt      = rk_r;
    acc_nxt     = acc_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    pending_nxt = pending_r;
    huff_nxt    = huff_r;
    nofield_nxt = nofield_r;
    err_nxt     = err_r;

    // Bytes are discarded while an error is pending.
    if (!err_r) begin
      case (phase_r)
        PH_FIRST: begin
          if (b[7]) begin
            rk_nxt   = REP_INDEXED;
            pmask    = 8'h7f;
            do_start = 1'b1;
          end else if (b[6]) begin
            rk_nxt   = REP_INCR;
            pmask    = 8'h3f;
            do_start = 1'b1;
          end else if (b[5]) begin
            if (!nofield_r) begin
              do_fail   = 1'b1;
              fail_code = ERR_LATE_SIZE;
            end else begin
              rk_nxt   = REP_SIZE;
              pmask    = 8'h1f;
              do_start = 1'b1;
            end
          end else begin
            rk_nxt   = b[4] ? REP_NEVER : REP_WITHOUT;
            pmask    = 8'h0f;
            do_start = 1'b1;
          end
        end
        PH_PFX_CONT: begin
          do_cont = 1'b1;
        end
        PH_LEN_FIRST: begin
          huff_nxt = b[7];
          pmask    = 8'h7f;
          do_start = 1'b1;
          in_str   = 1'b1;
        end
        PH_LEN_CONT: begin
          do_cont = 1'b1;
          in_str  = 1'b1;
        end
        PH_STRING: begin
          dec                 = left_r - 64'd1;
          left_nxt            = dec;
          tok_vld             = 1'b1;
          tok.token_kind      = TK_STR_BYTE;
          tok.string_is_value = isval;
          tok.string_byte     = b;
          tok.field_done      = (dec == 64'd0) && isval;
          do_finish           = (dec == 64'd0);
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase

      // First byte of a prefix integer.
      if (do_start) begin
        pv = b & pmask;
        if (pv != pmask) begin
          do_complete = 1'b1;
          cval        = {56'd0, pv};
        end else begin
          acc_nxt   = {56'd0, pv};
          shift_nxt = 6'd0;
          phase_nxt = in_str ? PH_LEN_CONT : PH_PFX_CONT;
        end
      end

      // Continuation byte: seven more bits at the current shift.
      if (do_cont) begin
        sum     = acc_r + ({57'd0, b[6:0]} << shift_r);
        acc_nxt = sum;
        if (!b[7]) begin
          do_complete = 1'b1;
          cval        = sum;
        end else begin
          shift_sum = {1'b0, shift_r} + {1'b0, SHIFT_STEP};
          shift_nxt = shift_sum[5:0];
          if (shift_sum >= SHIFT_LIMIT) begin
            do_fail   = 1'b1;
            fail_code = ERR_OVERFLOW;
          end
        end
      end

      // A finished integer, interpreted by what it belongs to.
      if (do_complete) begin
        if (in_str) begin
          tok_vld             = 1'b1;
          tok.token_kind      = TK_STR_HDR;
          tok.value           = cval;
          tok.is_huffman      = huff_nxt;
          tok.string_is_value = isval;
          tok.field_done      = (cval == 64'd0) && isval;
          if (cval == 64'd0) begin
            do_finish = 1'b1;
          end else begin
            left_nxt  = cval;
            phase_nxt = PH_STRING;
          end
        end else begin
          case (rk_nxt)
            REP_INDEXED: begin
              phase_nxt      = PH_FIRST;
              nofield_nxt    = 1'b0;
              tok_vld        = 1'b1;
              tok.token_kind = TK_INDEXED;
              tok.value      = cval;
              tok.field_done = 1'b1;
            end
            REP_SIZE: begin
              phase_nxt = PH_FIRST;
              if (cval > {32'd0, limit_r}) begin
                do_fail   = 1'b1;
                fail_code = ERR_OVER_LIM;
              end else begin
                tok_vld        = 1'b1;
                tok.token_kind = TK_SIZE_UPD;
                tok.value      = cval;
              end
            end
            default: begin
              pending_nxt    = (cval == 64'd0) ? 2'd2 : 2'd1;
              phase_nxt      = PH_LEN_FIRST;
              tok_vld        = 1'b1;
              tok.token_kind = TK_LITERAL;
              tok.value      = cval;
              tok.field_mode = 2'(rk_nxt - REP_INCR);
            end
          endcase
        end
      end

      // One string of the field is done.
      if (do_finish) begin
        pend_dec    = pending_r - 2'd1;
        pending_nxt = pend_dec;
        if (pend_dec == 2'd0) begin
          phase_nxt   = PH_FIRST;
          nofield_nxt = 1'b0;
        end else begin
          phase_nxt = PH_LEN_FIRST;
        end
      end

      // An error replaces the token and starts discarding.
      if (do_fail) begin
        err_nxt        = 1'b1;
        tok_vld        = 1'b1;
        tok            = '0;
        tok.token_kind = TK_ERROR;
        tok.error_code = fail_code;
      end
    end

    // Block end closes the block with one more result.
    if (item.block_end) begin
      if (!err_nxt && (phase_nxt != PH_FIRST)) begin
        close.token_kind = TK_ERROR;
        close.error_code = ERR_TRUNCATED;
      end else begin
        close.token_kind = TK_BLK_END;
      end
      close.last  = 1'b1;
      phase_nxt   = PH_FIRST;
      nofield_nxt = 1'b1;
      err_nxt     = 1'b0;
    end

    // Order the results: the byte's own token first, then the close.
    push = '0;
    if (tok_vld) begin
      tok.last = !item.block_end;
      push.r0  = tok;
      push.r1  = close;
    end else begin
      push.r0 = close;
    end
    if (fire) begin
      push.count = {1'b0, tok_vld} + {1'b0, item.block_end};
    end
  end

  // Decode state advances on each accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FIRST;
      rk_r      <= REP_INDEXED;
      acc_r     <= 64'd0;
      shift_r   <= 6'd0;
      left_r    <= 64'd0;
      pending_r <= 2'd0;
      huff_r    <= 1'b0;
      nofield_r <= 1'b1;
      err_r     <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      rk_r      <= rk_nxt;
      acc_r     <= acc_nxt;
      shift_r   <= shift_nxt;
      left_r    <= left_nxt;
      pending_r <= pending_nxt;
      huff_r    <= huff_nxt;
      nofield_r <= nofield_nxt;
      err_r     <= err_nxt;
    end
  end

  // Table size limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= HPK_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

endmodule

// File: design/hpk_result_queue.sv
// ----------------------------------------------------------------------------
// hpk_result_queue
// Small result queue that takes up to two words per cycle and hands out one
// word per cycle on a valid/stall channel.
// ----------------------------------------------------------------------------
module hpk_result_queue
  import hpk_pkg::*;
#(
  parameter int DEPTH = HPK_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_payload
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

  out_t          entry_r [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] tail_p1;
  logic [AW-1:0] tail_p2;
  logic          pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + AW'(1);
  endfunction

  // Room for a full pair of results.
  assign room        = (count_r <= ROOM_MAX);
  assign out_valid   = (count_r != '0);
  assign out_payload = entry_r[head_r];
  assign pop         = out_valid && !out_stall;
  assign tail_p1     = ptr_inc(tail_r);
  assign tail_p2     = ptr_inc(tail_p1);

  // Pointer and occupancy update.
  always_comb begin
    head_nxt  = pop ? ptr_inc(head_r) : head_r;
    case (push.count)
      2'd1:    tail_nxt = tail_p1;
      2'd2:    tail_nxt = tail_p2;
      default: tail_nxt = tail_r;
    endcase
    count_nxt = count_r + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry writes: first result at the tail, second one after it.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[tail_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entry_r[tail_p1] <= push.r1;
    end
  end

endmodule

// File: design/hpack_header_block_tokenizer.sv
// ----------------------------------------------------------------------------
// hpack_header_block_tokenizer
// Header block tokenizer: input word register, representation parser and
// result queue.
// ----------------------------------------------------------------------------
// The block takes one header block byte per cycle while in_stall is low and
// gives zero, one or two result words for it: the byte's own token, then, on
// the byte marked as the block end, a closing word. An accepted byte is held
// in the input register and enters the parser once the queue has room; its
// results reach out_valid through the result queue. Input is taken every
// cycle while the queue has room for two words, so the sustained rate is one
// byte per cycle as long as the consumer takes one word per cycle; a block
// end byte with a token puts two words in the queue. The user must make table
// size limit writes only while the block is idle; it is not enforced.
module hpack_header_block_tokenizer
  import hpk_pkg::*;
#(
  parameter int QUEUE_DEPTH = HPK_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_payload,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic  in_vld_r;
  in_t   in_item_r;
  logic  room;
  logic  fire;
  push_t push;

  // The registered word moves into the parser when the queue has room.
  assign fire     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_payload;
    end
  end

  hpk_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (in_item_r),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push)
  );

  hpk_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

  // A block end byte always yields at least the closing word.
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_item_r.block_end |-> push.count != 2'd0)
    else $error("block end byte produced no result");

  // A pair of results always ends with the closing word of the block.
  a_pair_closes: assert property (@(posedge clk) disable iff (!rst_n)
    push.count == 2'd2 |->
      (push.r1.token_kind == TK_BLK_END || push.r1.token_kind == TK_ERROR) &&
      !push.r0.last)
    else $error("second result of a byte is not a block close");

  // The final word of each byte carries the last mark.
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |->
      (push.count == 2'd1 && push.r0.last) || (push.count == 2'd2 && push.r1.last))
    else $error("last mark missing on final result");

endmodule
